@@ rtl/ac3df_pkg.sv @@
// Shared types, constants and the frame length table of the AC-3 sync frame deframer.
// No dependencies; the queue, front end, back end, top level and bench import this package.
package ac3df_pkg;

  localparam int HEADER_BYTES_DEF = 10;
  localparam int QUEUE_DEPTH      = 4;
  localparam int NUM_SIZE_CODES   = 38;

  localparam logic [7:0]  SYNC_BYTE0 = 8'h0B;
  localparam logic [7:0]  SYNC_BYTE1 = 8'h77;
  localparam logic [1:0]  FSCOD_RSVD = 2'd3;
  localparam logic [2:0]  ACMOD_2_0  = 3'd2;
  localparam logic [2:0]  ACMOD_1_0  = 3'd1;
  localparam logic [15:0] SKIP_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [1:0]  fscod;
    logic [5:0]  size_code;
    logic [4:0]  bsid;
    logic [3:0]  bsmod;
    logic [2:0]  acmod;
    logic        lfe_on;
    logic [11:0] frame_bytes;
    logic [15:0] skipped;
  } frame_info_t;

  // One queue entry: either a single payload byte or a command to emit the
  // buffered header bytes.
  typedef struct packed {
    logic        hdr_cmd;
    logic [7:0]  data;
    logic        first;
    logic        last;
    frame_info_t info;
  } q_entry_t;

  // Words per sync frame. Odd size codes differ from the even code below
  // them only at 44.1 kHz, by one word.
  function automatic logic [10:0] frame_words(input logic [5:0] size_code,
                                              input logic [1:0] fscod);
    logic [10:0] w48;
    logic [10:0] w44;
    logic [10:0] w32;
    logic [10:0] res;
    unique case (size_code[5:1])
      5'd0:    begin w48 = 11'd64;   w44 = 11'd69;   w32 = 11'd96;   end
      5'd1:    begin w48 = 11'd80;   w44 = 11'd87;   w32 = 11'd120;  end
      5'd2:    begin w48 = 11'd96;   w44 = 11'd104;  w32 = 11'd144;  end
      5'd3:    begin w48 = 11'd112;  w44 = 11'd121;  w32 = 11'd168;  end
      5'd4:    begin w48 = 11'd128;  w44 = 11'd139;  w32 = 11'd192;  end
      5'd5:    begin w48 = 11'd160;  w44 = 11'd174;  w32 = 11'd240;  end
      5'd6:    begin w48 = 11'd192;  w44 = 11'd208;  w32 = 11'd288;  end
      5'd7:    begin w48 = 11'd224;  w44 = 11'd243;  w32 = 11'd336;  end
      5'd8:    begin w48 = 11'd256;  w44 = 11'd278;  w32 = 11'd384;  end
      5'd9:    begin w48 = 11'd320;  w44 = 11'd348;  w32 = 11'd480;  end
      5'd10:   begin w48 = 11'd384;  w44 = 11'd417;  w32 = 11'd576;  end
      5'd11:   begin w48 = 11'd448;  w44 = 11'd487;  w32 = 11'd672;  end
      5'd12:   begin w48 = 11'd512;  w44 = 11'd557;  w32 = 11'd768;  end
      5'd13:   begin w48 = 11'd640;  w44 = 11'd696;  w32 = 11'd960;  end
      5'd14:   begin w48 = 11'd768;  w44 = 11'd835;  w32 = 11'd1152; end
      5'd15:   begin w48 = 11'd896;  w44 = 11'd975;  w32 = 11'd1344; end
      5'd16:   begin w48 = 11'd1024; w44 = 11'd1114; w32 = 11'd1536; end
      5'd17:   begin w48 = 11'd1152; w44 = 11'd1253; w32 = 11'd1728; end
      5'd18:   begin w48 = 11'd1280; w44 = 11'd1393; w32 = 11'd1920; end
      default: begin w48 = 11'd0;    w44 = 11'd0;    w32 = 11'd0;    end
    endcase
    unique case (fscod)
      2'd0:    res = w48;
      2'd1:    res = w44 + {10'd0, size_code[0]};
      2'd2:    res = w32;
      default: res = 11'd0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/ac3df_if.sv @@
// Channel interfaces of the AC-3 sync frame deframer: raw byte input and frame byte output.
// No dependencies.
interface ac3df_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ac3df_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        first_in_frame;
  logic        last_in_frame;
  logic [1:0]  sample_rate_code;
  logic [5:0]  frame_size_code;
  logic [4:0]  stream_id;
  logic [3:0]  service_mode;
  logic [2:0]  channel_mode;
  logic        lfe_on;
  logic [11:0] frame_bytes;
  logic [15:0] skipped_bytes;

  modport source (output valid, output out_byte, output first_in_frame,
                  output last_in_frame, output sample_rate_code,
                  output frame_size_code, output stream_id, output service_mode,
                  output channel_mode, output lfe_on, output frame_bytes,
                  output skipped_bytes, input ready);
  modport sink   (input valid, input out_byte, input first_in_frame,
                  input last_in_frame, input sample_rate_code,
                  input frame_size_code, input stream_id, input service_mode,
                  input channel_mode, input lfe_on, input frame_bytes,
                  input skipped_bytes, output ready);
endinterface

@@ rtl/ac3df_queue.sv @@
// Short FIFO of work entries between the deframer's front end and its output stage.
// Depends on ac3df_pkg.
module ac3df_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ac3df_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output ac3df_pkg::q_entry_t pop_data,
  output logic               empty
);
  import ac3df_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

  q_entry_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [PTR_W:0]   cnt_nxt;

  assign full     = (cnt_r == DEPTH_CNT);
  assign empty    = (cnt_r == '0);
  assign pop_data = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/ac3df_front.sv @@
// Front end of the deframer: sync hunt, header capture and check, skip counting.
// Depends on ac3df_pkg and ac3df_if; feeds ac3df_queue and shares the header buffer.
module ac3df_front #(
  parameter int HEADER_BYTES = ac3df_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ac3df_byte_if.sink          in_stream,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                q_push,
  output ac3df_pkg::q_entry_t q_push_data,
  input  logic                q_full,
  output logic [7:0]          hdr_store [HEADER_BYTES]
);
  import ac3df_pkg::*;

  localparam int CNT_W = $clog2(HEADER_BYTES + 1);
  localparam int IDX_W = $clog2(HEADER_BYTES);
  localparam logic [CNT_W-1:0] HB_CNT  = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] SYNC_LEN = CNT_W'(2);
  localparam logic [16:0]      HB_SKIP = 17'(HEADER_BYTES);
  localparam logic [11:0]      HB_LEN  = 12'(HEADER_BYTES);
  // With the shortest header the mode byte is the byte that completes it.
  localparam bit MODE_BYTE_LAST = (HEADER_BYTES == 7);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [11:0]      payload_left_r, payload_left_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic             first_pend_r, first_pend_nxt;
  frame_info_t      info_r, info_nxt;
  logic             strip_r;

  logic             accept;
  logic             store_we;
  logic [IDX_W-1:0] store_idx;
  logic [16:0]      skip_inc;
  logic [16:0]      skip_sum;
  logic [11:0]      left_dec;
  logic [CNT_W-1:0] cnt_inc;

  // Header decode
  logic [7:0]  mode_byte;
  logic [1:0]  fscod;
  logic [5:0]  size_code;
  logic [2:0]  acmod;
  logic [2:0]  lfe_pos;
  logic        hdr_ok;
  logic [11:0] total_len;
  frame_info_t new_info;

  assign in_stream.ready = !q_full;
  assign accept          = in_stream.valid && !q_full;

  assign mode_byte = MODE_BYTE_LAST ? in_stream.data_byte : hdr_store[6];
  assign fscod     = hdr_store[4][7:6];
  assign size_code = hdr_store[4][5:0];
  assign acmod     = mode_byte[7:5];
  assign hdr_ok    = (fscod != FSCOD_RSVD) && (size_code < 6'(NUM_SIZE_CODES));
  assign total_len = {frame_words(size_code, fscod), 1'b0};

  // lfeon follows the optional mix level and surround mode fields.
  always_comb begin
    lfe_pos = 3'd4;
    if (acmod == ACMOD_2_0) begin
      lfe_pos = 3'd2;
    end else begin
      if (acmod[0] && (acmod != ACMOD_1_0)) begin
        lfe_pos = lfe_pos - 3'd2;
      end
      if (acmod[2]) begin
        lfe_pos = lfe_pos - 3'd2;
      end
    end
  end

  always_comb begin
    new_info.fscod       = fscod;
    new_info.size_code   = size_code;
    new_info.bsid        = hdr_store[5][7:3];
    new_info.bsmod       = hdr_store[5][3:0];
    new_info.acmod       = acmod;
    new_info.lfe_on      = mode_byte[lfe_pos];
    new_info.frame_bytes = strip_r ? total_len - HB_LEN : total_len;
    new_info.skipped     = skip_r;
  end

  assign cnt_inc  = hdr_cnt_r + 1'b1;
  assign left_dec = (payload_left_r != '0) ? payload_left_r - 1'b1 : payload_left_r;
  assign skip_sum = {1'b0, skip_r} + skip_inc;

  always_comb begin
    phase_nxt        = phase_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    payload_left_nxt = payload_left_r;
    skip_nxt         = skip_r;
    first_pend_nxt   = first_pend_r;
    info_nxt         = info_r;
    skip_inc         = '0;
    store_we         = 1'b0;
    store_idx        = '0;
    q_push           = 1'b0;
    q_push_data.hdr_cmd = 1'b0;
    q_push_data.data    = in_stream.data_byte;
    q_push_data.first   = 1'b0;
    q_push_data.last    = 1'b0;
    q_push_data.info    = info_r;

    if (accept) begin
      unique case (phase_r)
        PH_HUNT0: begin
          if (in_stream.data_byte == SYNC_BYTE0) begin
            store_we  = 1'b1;
            phase_nxt = PH_HUNT1;
          end else begin
            skip_inc = 17'd1;
          end
        end
        PH_HUNT1: begin
          if (in_stream.data_byte == SYNC_BYTE1) begin
            store_we    = 1'b1;
            store_idx   = IDX_W'(1);
            hdr_cnt_nxt = SYNC_LEN;
            phase_nxt   = PH_HEADER;
          end else if (in_stream.data_byte == SYNC_BYTE0) begin
            // drop the old candidate, keep this one
            skip_inc = 17'd1;
          end else begin
            skip_inc  = 17'd2;
            phase_nxt = PH_HUNT0;
          end
        end
        PH_HEADER: begin
          store_we    = 1'b1;
          store_idx   = hdr_cnt_r[IDX_W-1:0];
          hdr_cnt_nxt = cnt_inc;
          if (cnt_inc == HB_CNT) begin
            hdr_cnt_nxt = '0;
            if (!hdr_ok) begin
              skip_inc  = HB_SKIP;
              phase_nxt = PH_HUNT0;
            end else begin
              info_nxt         = new_info;
              skip_nxt         = '0;
              payload_left_nxt = total_len - HB_LEN;
              first_pend_nxt   = strip_r;
              phase_nxt        = PH_PAYLOAD;
              if (!strip_r) begin
                q_push              = 1'b1;
                q_push_data.hdr_cmd = 1'b1;
                q_push_data.info    = new_info;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          q_push            = 1'b1;
          q_push_data.first = first_pend_r;
          q_push_data.last  = (left_dec == '0);
          first_pend_nxt    = 1'b0;
          payload_left_nxt  = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_HUNT0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT0;
        end
      endcase
      if (skip_inc != '0) begin
        skip_nxt = skip_sum[16] ? SKIP_MAX : skip_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT0;
      hdr_cnt_r      <= '0;
      payload_left_r <= '0;
      skip_r         <= '0;
      first_pend_r   <= 1'b0;
      info_r         <= '0;
      strip_r        <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      hdr_cnt_r      <= hdr_cnt_nxt;
      payload_left_r <= payload_left_nxt;
      skip_r         <= skip_nxt;
      first_pend_r   <= first_pend_nxt;
      info_r         <= info_nxt;
      if (cfg_wr_en) begin
        strip_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      hdr_store[store_idx] <= in_stream.data_byte;
    end
  end

endmodule

@@ rtl/ac3df_back.sv @@
// Back end of the deframer: pops work entries, replays the header buffer, drives the output register.
// Depends on ac3df_pkg and ac3df_if; reads the header buffer held by ac3df_front.
module ac3df_back #(
  parameter int HEADER_BYTES = ac3df_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ac3df_pkg::q_entry_t q_pop_data,
  output logic                q_pop,
  input  logic [7:0]          hdr_store [HEADER_BYTES],
  ac3df_frame_if.source       out_stream
);
  import ac3df_pkg::*;

  localparam int IDX_W = $clog2(HEADER_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEADER_BYTES - 1);

  logic             out_valid_r, out_valid_nxt;
  q_entry_t         out_ent_r, out_ent_nxt;
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  frame_info_t      hdr_info_r, hdr_info_nxt;
  logic             can_load;

  assign can_load = !out_valid_r || out_stream.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ent_nxt   = out_ent_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    hdr_info_nxt  = hdr_info_r;
    q_pop         = 1'b0;
    if (can_load) begin
      out_valid_nxt = 1'b0;
      if (busy_r) begin
        // replay the rest of the header, one byte per cycle while the output can load
        out_valid_nxt       = 1'b1;
        out_ent_nxt.hdr_cmd = 1'b0;
        out_ent_nxt.data    = hdr_store[idx_r];
        out_ent_nxt.first   = 1'b0;
        out_ent_nxt.last    = 1'b0;
        out_ent_nxt.info    = hdr_info_r;
        idx_nxt             = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          busy_nxt = 1'b0;
        end
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_ent_nxt   = q_pop_data;
        if (q_pop_data.hdr_cmd) begin
          out_ent_nxt.hdr_cmd = 1'b0;
          out_ent_nxt.data    = hdr_store[0];
          out_ent_nxt.first   = 1'b1;
          out_ent_nxt.last    = 1'b0;
          hdr_info_nxt        = q_pop_data.info;
          busy_nxt            = 1'b1;
          idx_nxt             = IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ent_r  <= out_ent_nxt;
    hdr_info_r <= hdr_info_nxt;
  end

  assign out_stream.valid            = out_valid_r;
  assign out_stream.out_byte         = out_ent_r.data;
  assign out_stream.first_in_frame   = out_ent_r.first;
  assign out_stream.last_in_frame    = out_ent_r.last;
  assign out_stream.sample_rate_code = out_ent_r.info.fscod;
  assign out_stream.frame_size_code  = out_ent_r.info.size_code;
  assign out_stream.stream_id        = out_ent_r.info.bsid;
  assign out_stream.service_mode     = out_ent_r.info.bsmod;
  assign out_stream.channel_mode     = out_ent_r.info.acmod;
  assign out_stream.lfe_on           = out_ent_r.info.lfe_on;
  assign out_stream.frame_bytes      = out_ent_r.info.frame_bytes;
  assign out_stream.skipped_bytes    = out_ent_r.info.skipped;

endmodule

@@ rtl/ac3_syncframe_deframer_top.sv @@
// Top level of the AC-3 sync frame deframer: front end, work queue and output stage.
// Depends on ac3df_pkg, ac3df_if, ac3df_front, ac3df_queue and ac3df_back.
//
// Usage:
//   in_stream carries the raw AC-3 elementary stream, one byte per transaction.
//   out_stream carries the bytes of each valid sync frame, in stream order,
//   each tagged with first/last marks, the frame's header fields, its emitted
//   length and the count of bytes discarded ahead of its sync word.
//   cfg_wr_en/cfg_wr_data write the strip-header bit; it is sampled when a
//   header completes and holds for that frame. Write it only while idle.
// Path: an accepted payload byte passes through the work queue into the
//   output register, which drives out_stream. Once its replay command leaves
//   the queue, the header is replayed from its buffer one byte per cycle unless stalled.
// Throughput: one byte per cycle sustained while out_stream is not stalled;
//   the output stage moves one byte per cycle, so a header replay holds back
//   the following payload, absorbed by the queue and then by in_stream.ready.
// Reset: hunt for the first sync byte, strip bit cleared, queue empty,
//   skip count zero.
// Stall: while out_stream is stalled the output register holds; the queue
//   fills and then in_stream.ready drops until the receiver takes data.
module ac3_syncframe_deframer_top #(
  parameter int HEADER_BYTES = ac3df_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ac3df_byte_if.sink    in_stream,
  ac3df_frame_if.source out_stream,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);
  import ac3df_pkg::*;

  logic       q_push;
  q_entry_t   q_push_data;
  logic       q_full;
  logic       q_pop;
  q_entry_t   q_pop_data;
  logic       q_empty;
  logic [7:0] hdr_store [HEADER_BYTES];

  // Classify each incoming byte; push payload bytes and header replay commands.
  ac3df_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stream   (in_stream),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_full      (q_full),
    .hdr_store   (hdr_store)
  );

  // Decouple the hunt from the output stage. Its depth stays far below the
  // shortest payload, so the header buffer is never rewritten before replay ends.
  ac3df_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Drain the queue into the output register; replay headers byte by byte.
  ac3df_back #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop_data (q_pop_data),
    .q_pop      (q_pop),
    .hdr_store  (hdr_store),
    .out_stream (out_stream)
  );

  // The front end only pushes when it has taken an input, which it does only
  // with room in the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("work queue overflow");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty work queue");

  // Every frame is far longer than one byte.
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid |-> !(out_stream.first_in_frame && out_stream.last_in_frame))
    else $error("frame marked first and last on one byte");

  // Only checked headers reach the output.
  a_valid_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid |-> (out_stream.sample_rate_code != FSCOD_RSVD) &&
                         (out_stream.frame_size_code < 6'(NUM_SIZE_CODES)))
    else $error("reserved header code on output");

endmodule

@@ bench/tb_ac3_syncframe_deframer_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ac3_syncframe_deframer_top: directed frame table, then random frames.
// Depends on ac3df_pkg, ac3df_if and the deframer RTL; a built-in frame parser predicts output.
module tb_ac3_syncframe_deframer_top;
  import ac3df_pkg::*;

  localparam int HDR_LEN       = HEADER_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SEGS_PER_PASS = 24;
  localparam int RANDOM_PASSES = 4;
  localparam int WANT_NONE     = -1;
  localparam int MAX_REPORTS   = 40;
  localparam int DIR_ROWS      = 15;

  // How the directed sync word is approached: clean, with a repeated first sync
  // byte, or after a first sync byte that is not followed by the second one.
  typedef enum logic [1:0] {
    LEAD_PLAIN,
    LEAD_DOUBLE_SYNC,
    LEAD_BROKEN_SYNC
  } lead_e;

  typedef enum logic {
    ROW_FRAME,
    ROW_BAD_HEADER
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    int         lead_len;
    logic [7:0] lead_val;
    lead_e      lead;
    logic       strip;
    logic [1:0] fscod;
    logic [5:0] code;
    logic [7:0] b5;
    logic [7:0] b6;
    int         want_len;
    int         want_skip;
  } dir_row_t;

  // One emitted frame byte as the parser expects it.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    frame_info_t info;
  } frame_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  ac3df_byte_if  in_if ();
  ac3df_frame_if out_if ();

  ac3_syncframe_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Words per sync frame, one row per size code: 48 kHz, 44.1 kHz, 32 kHz.
  int unsigned words_tbl [NUM_SIZE_CODES][3] = '{
    '{64, 69, 96},     '{64, 70, 96},     '{80, 87, 120},    '{80, 88, 120},
    '{96, 104, 144},   '{96, 105, 144},   '{112, 121, 168},  '{112, 122, 168},
    '{128, 139, 192},  '{128, 140, 192},  '{160, 174, 240},  '{160, 175, 240},
    '{192, 208, 288},  '{192, 209, 288},  '{224, 243, 336},  '{224, 244, 336},
    '{256, 278, 384},  '{256, 279, 384},  '{320, 348, 480},  '{320, 349, 480},
    '{384, 417, 576},  '{384, 418, 576},  '{448, 487, 672},  '{448, 488, 672},
    '{512, 557, 768},  '{512, 558, 768},  '{640, 696, 960},  '{640, 697, 960},
    '{768, 835, 1152}, '{768, 836, 1152}, '{896, 975, 1344}, '{896, 976, 1344},
    '{1024, 1114, 1536}, '{1024, 1115, 1536}, '{1152, 1253, 1728},
    '{1152, 1254, 1728}, '{1280, 1393, 1920}, '{1280, 1394, 1920}
  };

  // Directed frames. Typed lengths and skip counts are the ones readable from
  // the frame table directly; rows with WANT_NONE rely on the parser alone.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // first frame after reset, smallest size
    '{ROW_FRAME, 0, 8'h00, LEAD_PLAIN, 1'b0, 2'd0, 6'd0, 8'h08, 8'h00, 128, 0},
    // all-ones noise ahead, all-ones bsid/bsmod/acmod
    '{ROW_FRAME, 3, 8'hFF, LEAD_PLAIN, 1'b0, 2'd0, 6'd1, 8'hFF, 8'hFF, 128, 3},
    // repeated first sync byte, 2/0 mode with lfe set
    '{ROW_FRAME, 1, 8'h00, LEAD_DOUBLE_SYNC, 1'b0, 2'd1, 6'd1, 8'h00, 8'h44, 140, 2},
    // broken sync word, 1/0 mode with lfe set
    '{ROW_FRAME, 0, 8'h00, LEAD_BROKEN_SYNC, 1'b0, 2'd2, 6'd0, 8'h00, 8'h30, 192, 2},
    // reserved rate code, then size codes past the table
    '{ROW_BAD_HEADER, 0, 8'h00, LEAD_PLAIN, 1'b0, 2'd3, 6'd0, 8'h00, 8'h00,
      WANT_NONE, WANT_NONE},
    '{ROW_BAD_HEADER, 0, 8'h00, LEAD_PLAIN, 1'b0, 2'd0, 6'd38, 8'h00, 8'h00,
      WANT_NONE, WANT_NONE},
    '{ROW_BAD_HEADER, 0, 8'h00, LEAD_PLAIN, 1'b0, 2'd2, 6'd63, 8'hFF, 8'hFF,
      WANT_NONE, WANT_NONE},
    // largest frame, inherits the three discarded headers
    '{ROW_FRAME, 0, 8'h00, LEAD_PLAIN, 1'b0, 2'd2, 6'd37, 8'h40, 8'hA8, 3840, 30},
    // header stripped: smallest 48 kHz and largest 44.1 kHz
    '{ROW_FRAME, 0, 8'h00, LEAD_PLAIN, 1'b1, 2'd0, 6'd0, 8'h10, 8'h60, 118, 0},
    '{ROW_FRAME, 0, 8'h00, LEAD_PLAIN, 1'b1, 2'd1, 6'd37, 8'h21, 8'hE4, 2778, 0},
    // run of first sync bytes before the real sync word
    '{ROW_FRAME, 2, 8'h0B, LEAD_PLAIN, 1'b1, 2'd0, 6'd2, 8'h3A, 8'hD6, 150, 2},
    '{ROW_BAD_HEADER, 0, 8'h00, LEAD_PLAIN, 1'b1, 2'd3, 6'd63, 8'h00, 8'h00,
      WANT_NONE, WANT_NONE},
    // skip counter saturates
    '{ROW_FRAME, 65540, 8'h5A, LEAD_PLAIN, 1'b0, 2'd0, 6'd0, 8'h55, 8'h80, 128, 65535},
    // counter cleared by the previous frame
    '{ROW_FRAME, 0, 8'h00, LEAD_PLAIN, 1'b0, 2'd1, 6'd0, 8'hAA, 8'h1F, 138, 0},
    // stray second sync byte while hunting
    '{ROW_FRAME, 1, 8'h77, LEAD_PLAIN, 1'b0, 2'd2, 6'd18, 8'hC7, 8'h52, 960, 1}
  };

  // Parser state, mirrored from the block's behavior.
  phase_t      parse_state;
  int          hdr_fill;
  logic [7:0]  hdr_buf [HDR_LEN];
  int unsigned bytes_left;
  int unsigned skip_total;
  frame_info_t cur_info;
  logic        first_due;
  logic        strip_cfg;

  frame_beat_t expected_beats [$];

  int errors;
  int cycle_count;
  int bytes_sent;
  int beats_checked;
  int frames_predicted;
  int headers_dropped;
  int last_len;
  int last_skip;

  // Idle shaping, set per pass.
  int tx_gap_pct;
  int rx_stall_pct;
  int tx_burst_left;
  int rx_hold;

  function automatic void report(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic void add_skip(int unsigned n);
    skip_total = (skip_total + n > SKIP_MAX) ? SKIP_MAX : skip_total + n;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == SYNC_BYTE0) ? 8'hF4 : b;
  endfunction

  // Advance the parser by one accepted byte; queue the frame bytes it releases.
  task automatic predict_byte(input logic [7:0] b);
    frame_beat_t beat;
    logic [1:0]  fs;
    logic [5:0]  code;
    logic [2:0]  acmod;
    int          shift;
    int unsigned total;
    case (parse_state)
      PH_HUNT0: begin
        if (b == SYNC_BYTE0) begin
          hdr_buf[0] = b;
          parse_state = PH_HUNT1;
        end else begin
          add_skip(1);
        end
      end
      PH_HUNT1: begin
        if (b == SYNC_BYTE1) begin
          hdr_buf[1] = b;
          hdr_fill = 2;
          parse_state = PH_HEADER;
        end else begin
          // The held sync byte is lost; a new sync byte takes its place.
          add_skip(1);
          if (b != SYNC_BYTE0) begin
            add_skip(1);
            parse_state = PH_HUNT0;
          end
        end
      end
      PH_HEADER: begin
        hdr_buf[hdr_fill] = b;
        hdr_fill++;
        if (hdr_fill == HDR_LEN) begin
          hdr_fill = 0;
          fs = hdr_buf[4][7:6];
          code = hdr_buf[4][5:0];
          if (fs == FSCOD_RSVD || code >= NUM_SIZE_CODES) begin
            // Drop the whole header and restart the hunt after it.
            add_skip(HDR_LEN);
            parse_state = PH_HUNT0;
            headers_dropped++;
          end else begin
            acmod = hdr_buf[6][7:5];
            shift = 4;
            if (acmod == ACMOD_2_0) begin
              shift -= 2;
            end else begin
              if (acmod[0] && acmod != ACMOD_1_0) shift -= 2;
              if (acmod[2]) shift -= 2;
            end
            total = 2 * words_tbl[code][fs];
            cur_info.fscod = fs;
            cur_info.size_code = code;
            cur_info.bsid = hdr_buf[5][7:3];
            cur_info.bsmod = hdr_buf[5][3:0];
            cur_info.acmod = acmod;
            cur_info.lfe_on = hdr_buf[6][shift];
            cur_info.frame_bytes = 12'(strip_cfg ? total - HDR_LEN : total);
            cur_info.skipped = 16'(skip_total);
            skip_total = 0;
            bytes_left = total - HDR_LEN;
            parse_state = PH_PAYLOAD;
            first_due = strip_cfg;
            if (!strip_cfg) begin
              for (int i = 0; i < HDR_LEN; i++) begin
                beat.data = hdr_buf[i];
                beat.first = (i == 0);
                beat.last = 1'b0;
                beat.info = cur_info;
                expected_beats.push_back(beat);
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        beat.data = b;
        beat.first = first_due;
        first_due = 1'b0;
        bytes_left--;
        beat.last = (bytes_left == 0);
        beat.info = cur_info;
        expected_beats.push_back(beat);
        if (beat.last) begin
          parse_state = PH_HUNT0;
          frames_predicted++;
        end
      end
      default: parse_state = PH_HUNT0;
    endcase
  endtask

  // Offer one byte; the sender works in bursts with random gaps between them.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    tx_burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    bytes_sent++;
    predict_byte(b);
  endtask

  task automatic send_header(input logic [1:0] fs, input logic [5:0] code,
                             input logic [7:0] b5, input logic [7:0] b6);
    send_byte(SYNC_BYTE0);
    send_byte(SYNC_BYTE1);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    send_byte({fs, code});
    send_byte(b5);
    send_byte(b6);
    repeat (HDR_LEN - 7) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input logic [1:0] fs, input logic [5:0] code,
                            input logic [7:0] b5, input logic [7:0] b6);
    send_header(fs, code, b5, b6);
    repeat (2 * words_tbl[code][fs] - HDR_LEN) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold the input idle until every queued frame byte has come out, then give
  // a pending header replay time to finish.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (2 * HDR_LEN + 4) @(posedge clk);
  endtask

  task automatic write_strip(input logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    strip_cfg = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Receiver: ready stalls in random holds; the stall rate changes per pass.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold--;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_if.ready <= 1'b0;
      rx_hold = $urandom_range(0, 7);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare every accepted frame byte with the oldest expectation.
  always @(posedge clk) begin : frame_check
    frame_beat_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: frame byte %0h with nothing expected, expected none, got %0h",
                   $time, out_if.out_byte, out_if.out_byte);
      end else begin
        want = expected_beats.pop_front();
        report("out_byte", want.data, out_if.out_byte);
        report("first_in_frame", want.first, out_if.first_in_frame);
        report("last_in_frame", want.last, out_if.last_in_frame);
        report("sample_rate_code", want.info.fscod, out_if.sample_rate_code);
        report("frame_size_code", want.info.size_code, out_if.frame_size_code);
        report("stream_id", want.info.bsid, out_if.stream_id);
        report("service_mode", want.info.bsmod, out_if.service_mode);
        report("channel_mode", want.info.acmod, out_if.channel_mode);
        report("lfe_on", want.info.lfe_on, out_if.lfe_on);
        report("frame_bytes", want.info.frame_bytes, out_if.frame_bytes);
        report("skipped_bytes", want.info.skipped, out_if.skipped_bytes);
        beats_checked++;
        last_len = out_if.frame_bytes;
        last_skip = out_if.skipped_bytes;
      end
    end
  end

  // Watchdog: end the run if the stream stops moving.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frame bytes still expected",
               cycle_count, expected_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    logic [1:0] fs;
    logic [5:0] code;
    logic [7:0] b;
    int         pick;
    // Drive every input to a known value before the first edge.
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    out_if.ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    bytes_sent = 0;
    beats_checked = 0;
    frames_predicted = 0;
    headers_dropped = 0;
    last_len = 0;
    last_skip = 0;
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    tx_burst_left = 0;
    rx_hold = 0;
    // Parser starts in its reset state.
    parse_state = PH_HUNT0;
    hdr_fill = 0;
    bytes_left = 0;
    skip_total = 0;
    cur_info = '0;
    first_due = 1'b0;
    strip_cfg = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames: walk the table, draining after each row so the typed
    // length and skip count can be read off the last byte of the frame.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      if (row.strip != strip_cfg) write_strip(row.strip);
      repeat (row.lead_len) send_byte(row.lead_val);
      case (row.lead)
        LEAD_DOUBLE_SYNC: send_byte(SYNC_BYTE0);
        LEAD_BROKEN_SYNC: begin
          send_byte(SYNC_BYTE0);
          send_byte(8'h00);
        end
        default: ;
      endcase
      if (row.kind == ROW_FRAME) send_frame(row.fscod, row.code, row.b5, row.b6);
      else send_header(row.fscod, row.code, row.b5, row.b6);
      drain();
      if (row.want_len != WANT_NONE) begin
        report("directed frame_bytes", 16'(row.want_len), 16'(last_len));
        report("directed skipped_bytes", 16'(row.want_skip), 16'(last_skip));
      end
    end

    // Random passes: strip setting alternates, idle pressure varies, and one
    // pass runs with neither side idling.
    for (int p = 0; p < RANDOM_PASSES; p++) begin
      drain();
      write_strip(~p[0]);
      case (p)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 40; rx_stall_pct = 30; end
        2: begin tx_gap_pct = 10; rx_stall_pct = 60; end
        default: begin tx_gap_pct = 70; rx_stall_pct = 10; end
      endcase
      repeat (SEGS_PER_PASS) begin
        pick = $urandom_range(0, 99);
        fs = 2'($urandom_range(0, 2));
        code = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                                : $urandom_range(0, NUM_SIZE_CODES - 1));
        if (pick < 70) begin
          // Well-formed frame, a little noise ahead.
          repeat ($urandom_range(0, 3)) send_byte(noise_byte());
          send_frame(fs, code, 8'($urandom), 8'($urandom));
        end else if (pick < 80) begin
          // First sync byte not followed by the second, then a frame.
          send_byte(SYNC_BYTE0);
          b = 8'($urandom_range(0, 255));
          send_byte((b == SYNC_BYTE1) ? SYNC_BYTE0 : b);
          send_frame(fs, code, 8'($urandom), 8'($urandom));
        end else if (pick < 90) begin
          // Header with a reserved rate or out-of-table size.
          if ($urandom_range(0, 1) == 1) begin
            fs = FSCOD_RSVD;
            code = 6'($urandom_range(0, 63));
          end else begin
            code = 6'($urandom_range(NUM_SIZE_CODES, 63));
          end
          send_header(fs, code, 8'($urandom), 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 20)) send_byte(noise_byte());
        end
      end
    end
    drain();

    $display("Run covered %0d frames and %0d discarded headers from %0d input bytes;",
             frames_predicted, headers_dropped, bytes_sent);
    $display("%0d frame bytes checked field by field, with and without header strip.",
             beats_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
